// ===== rtl/priority_task_table_core_macros.svh =====
// Assertion macros for the priority task table core.
`ifndef PRIORITY_TASK_TABLE_CORE_MACROS_SVH
`define PRIORITY_TASK_TABLE_CORE_MACROS_SVH

// Same-cycle implication under reset.
`define PTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ptt_pkg.sv =====
// Shared types and constants for the priority task table.
`timescale 1ns / 1ps

package ptt_pkg;

	localparam int TABLE_SLOTS_DEF = 32;
	localparam int ID_W            = 16;
	localparam int PRIO_W          = 16;
	localparam int STAMP_W         = 32;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_CANCEL = 2'd1,
		MODE_CHANGE = 2'd2,
		MODE_EXEC   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR  = 2'd0,
		S_IDLE   = 2'd1,
		S_SCAN   = 2'd2,
		S_UPDATE = 2'd3
	} state_t;

	typedef struct packed {
		logic                     valid;
		logic [ID_W-1:0]          id;
		logic signed [PRIO_W-1:0] prio;
		logic [STAMP_W-1:0]       stamp;
	} slot_t;

endpackage

// ===== rtl/priority_task_table_core.sv =====
// Top level of the priority task table: sequencer, slot scan and result register.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tuser: mode; tdata: task_id, task_priority
//  m_*     | out | m_tvalid/m_tready  | tuser: status; tdata: done_id, done_priority
//
// Each request runs through the accept in S_IDLE, a scan in S_SCAN that reads the slot memory
// once per slot and waits out the registered read and a settle step, and the update in S_UPDATE.
// After reset a clearing pass writes every slot and marks all slots free; s_tready
// stays low until it ends. A new request is taken while a result waits on m_*;
// the update cycle holds until the result register is free.
`timescale 1ns / 1ps
`include "priority_task_table_core_macros.svh"

module priority_task_table_core import ptt_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] task_id, [31:16] task_priority
	input  logic [1:0]  s_tuser,  // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] done_id, [31:16] done_priority
	output logic [1:0]  m_tuser   // [1:0] status
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	state_t state_q, state_d;

	logic [CW-1:0]            cnt_q;
	logic                     rd_vld_s1;
	logic [AW-1:0]            addr_s1;
	mode_t                    mode_q;
	logic [ID_W-1:0]          id_q;
	logic signed [PRIO_W-1:0] prio_q;
	logic [STAMP_W-1:0]       stamp_q;

	logic                     hit_q;
	logic [AW-1:0]            hit_idx_q;
	logic                     free_q;
	logic [AW-1:0]            free_idx_q;
	logic                     best_q;
	logic [AW-1:0]            best_idx_q;
	logic [ID_W-1:0]          best_id_q;
	logic signed [PRIO_W-1:0] best_prio_q;
	logic [STAMP_W-1:0]       best_stamp_q;

	logic                     out_vld_q;
	status_t                  out_status_q;
	logic [ID_W-1:0]          out_id_q;
	logic signed [PRIO_W-1:0] out_prio_q;

	logic          issue;
	logic          accept;
	logic          upd_fire;
	logic          take_stamp;
	status_t       status_d;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	slot_t         wr_data;
	slot_t         rd_data;
	logic          better;

	ptt_store #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.AW         (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(cnt_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign issue  = (state_q == S_SCAN) && (cnt_q < CW'(TABLE_SLOTS));
	assign accept = s_tvalid && s_tready;

	assign better = !best_q || (rd_data.prio > best_prio_q) ||
		((rd_data.prio == best_prio_q) && (rd_data.stamp < best_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		upd_fire   = 1'b0;
		take_stamp = 1'b0;
		status_d   = ST_DONE;
		wr_en      = 1'b0;
		wr_addr    = cnt_q[AW-1:0];
		wr_data    = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				if (cnt_q[AW-1:0] == AW'(TABLE_SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!issue && !rd_vld_s1) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				upd_fire = !out_vld_q || m_tready;
				case (mode_q)
					MODE_ADD: begin
						if (hit_q) begin
							status_d = ST_IGNORED;
						end else if (!free_q) begin
							status_d = ST_FULL;
						end else begin
							wr_en      = upd_fire;
							take_stamp = upd_fire;
							wr_addr    = free_idx_q;
							wr_data    = '{valid: 1'b1, id: id_q, prio: prio_q, stamp: stamp_q};
						end
					end
					MODE_CANCEL: begin
						if (!hit_q) begin
							status_d = ST_IGNORED;
						end else begin
							wr_en   = upd_fire;
							wr_addr = hit_idx_q;
						end
					end
					MODE_CHANGE: begin
						if (!hit_q) begin
							status_d = ST_IGNORED;
						end else begin
							wr_en      = upd_fire;
							take_stamp = upd_fire;
							wr_addr    = hit_idx_q;
							wr_data    = '{valid: 1'b1, id: id_q, prio: prio_q, stamp: stamp_q};
						end
					end
					default: begin
						if (!best_q) begin
							status_d = ST_EMPTY;
						end else begin
							wr_en   = upd_fire;
							wr_addr = best_idx_q;
						end
					end
				endcase
				if (upd_fire) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			best_q    <= 1'b0;
			stamp_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			case (state_q)
				S_CLEAR: cnt_q <= cnt_q + CW'(1);
				S_IDLE:  cnt_q <= '0;
				S_SCAN:  if (issue) cnt_q <= cnt_q + CW'(1);
				default: cnt_q <= cnt_q;
			endcase
			if (accept) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				best_q <= 1'b0;
			end else if (rd_vld_s1) begin
				if (rd_data.valid && (rd_data.id == id_q) && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!rd_data.valid && !free_q) begin
					free_q <= 1'b1;
				end
				if (rd_data.valid && better) begin
					best_q <= 1'b1;
				end
			end
			if (take_stamp && (stamp_q != '1)) begin
				stamp_q <= stamp_q + STAMP_W'(1);
			end
			if (upd_fire) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q[AW-1:0];
		if (accept) begin
			mode_q <= mode_t'(s_tuser);
			id_q   <= s_tdata[15:0];
			prio_q <= s_tdata[31:16];
		end
		if (rd_vld_s1) begin
			if (rd_data.valid && (rd_data.id == id_q) && !hit_q) begin
				hit_idx_q <= addr_s1;
			end
			if (!rd_data.valid && !free_q) begin
				free_idx_q <= addr_s1;
			end
			if (rd_data.valid && better) begin
				best_idx_q   <= addr_s1;
				best_id_q    <= rd_data.id;
				best_prio_q  <= rd_data.prio;
				best_stamp_q <= rd_data.stamp;
			end
		end
		if (upd_fire) begin
			out_status_q <= status_d;
			if ((mode_q == MODE_EXEC) && best_q) begin
				out_id_q   <= best_id_q;
				out_prio_q <= best_prio_q;
			end else begin
				out_id_q   <= '0;
				out_prio_q <= '0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_prio_q, out_id_q};

	`PTT_ASSERT_NEXT(a_accept_scans, s_tvalid && s_tready, state_q == S_SCAN, "accept did not start scan")
	`PTT_ASSERT_NOW(a_no_write_in_scan, state_q == S_SCAN, !wr_en, "slot write during scan")
	`PTT_ASSERT_NEXT(a_stamp_monotone, 1'b1, stamp_q >= $past(stamp_q), "stamp went backward")
	`PTT_ASSERT_NOW(a_empty_zero, m_tvalid && (m_tuser == ST_EMPTY), m_tdata == 32'd0, "empty result carries data")

endmodule

// ===== rtl/ptt_store.sv =====
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ptt_store import ptt_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
	parameter int AW          = $clog2(TABLE_SLOTS)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  slot_t         wr_data,
	input  logic [AW-1:0] rd_addr,
	output slot_t         rd_data
);

	slot_t mem_q [TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
